FILE: hw/rtl/ssd_pkg.sv
// Shared types, codes and the glyph table of the seven-segment line driver.
`default_nettype none
package ssd_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int DOTPOSITION = 7;
  localparam int GLYPH_COUNT = 69;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int MIRROR_W = 64;
  localparam int CNT_W = $clog2(MIRROR_W + 1);
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);

  // input kinds
  localparam logic [2:0] KIND_PRINT   = 3'd0;
  localparam logic [2:0] KIND_RAW_LAT = 3'd1;
  localparam logic [2:0] KIND_RAW_UNL = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_DOTS    = 3'd4;
  localparam logic [2:0] KIND_REFRESH = 3'd5;

  // dot modes
  localparam logic [1:0] DOT_CLEAR = 2'd1;
  localparam logic [1:0] DOT_SET   = 2'd2;

  // queued back-end operations
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_DOTS    = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  localparam logic [3:0] LINE_LENGTH_RST = 4'd8;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] code;
    logic [1:0] dot_mode;
  } in_item_t;

  typedef struct packed {
    logic data_bit;
    logic latch_after;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        data;    // segment byte or dot mask
    logic              latch;
    logic [NDIG_W-1:0] ndig;    // digits for a clear, 1..MAX_DIGITS
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
    8'hC8, 8'h0A, 8'h7F, 8'h6E, 8'h99, 8'h3F, 8'h00, 8'h16, 8'h4C, 8'h2B, 8'h49, 8'h40,
    8'h01, 8'h80, 8'h19, 8'h7E, 8'h48, 8'h3D, 8'h6D, 8'h4B, 8'h67, 8'h77, 8'h4C, 8'h7F,
    8'h6F, 8'h81, 8'hC0, 8'h39, 8'h21, 8'h63, 8'h9D, 8'h5D,
    8'h5F, 8'h73, 8'h31, 8'h79, 8'h37, 8'h17, 8'h76, 8'h53, 8'h12, 8'h78, 8'h3B, 8'h32,
    8'h5E, 8'h51, 8'h71, 8'h1F, 8'h4F, 8'h57, 8'h66, 8'h4C, 8'h70, 8'h2A, 8'h7A, 8'h5B,
    8'h6B, 8'h3C,
    8'h36, 8'h43, 8'h6C, 8'h0E, 8'h20, 8'h08, 8'h27, 8'h5A, 8'h2D, 8'h75, 8'h0F
  };

  function automatic logic [7:0] encode_char(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] toggle;
    logic [7:0] idx;
    logic [7:0] res;
    c      = {1'b0, ch[6:0]};
    toggle = {ch[7], 7'b0};
    if (c > 8'd96) begin
      if (c > 8'd122) begin
        c = c + 8'd6;
      end
      c = c - 8'd32;
    end
    idx = c - 8'd33;
    if (idx >= 8'(GLYPH_COUNT)) begin
      idx = 8'(GLYPH_COUNT - 1);
    end
    if (ch[6:0] == 7'd10) begin
      res = 8'h00;
    end else if (ch[6:0] < 7'd33) begin
      res = 8'hFF ^ toggle;
    end else begin
      res = GLYPHS[idx[GLYPH_IDX_W-1:0]] ^ toggle;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ssd_front.sv
// Front end: accepts items, encodes characters and queues back-end commands.
`default_nettype none
module ssd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ssd_pkg::in_item_t in_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [3:0]       cfg_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output ssd_pkg::cmd_t         q_cmd
);

  logic [3:0] line_length_r;
  logic [3:0] line_length_nxt;
  logic [7:0] ch;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  assign line_length_nxt = (cfg_valid && cfg_ready) ? cfg_data : line_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= ssd_pkg::LINE_LENGTH_RST;
    end else begin
      line_length_r <= line_length_nxt;
    end
  end

  always_comb begin
    unique case (in_data.dot_mode)
      ssd_pkg::DOT_CLEAR: ch = {1'b0, in_data.code[6:0]};
      ssd_pkg::DOT_SET:   ch = {1'b1, in_data.code[6:0]};
      default:            ch = in_data.code;
    endcase
  end

  always_comb begin
    q_cmd.op    = ssd_pkg::OP_PUSH;
    q_cmd.data  = in_data.code;
    q_cmd.latch = 1'b1;
    if (line_length_r == 4'd0) begin
      q_cmd.ndig = ssd_pkg::NDIG_W'(1);
    end else if (line_length_r > 4'(ssd_pkg::MAX_DIGITS)) begin
      q_cmd.ndig = ssd_pkg::NDIG_W'(ssd_pkg::MAX_DIGITS);
    end else begin
      q_cmd.ndig = ssd_pkg::NDIG_W'(line_length_r);
    end
    q_push = accept;
    unique case (in_data.kind)
      ssd_pkg::KIND_PRINT:   q_cmd.data = ssd_pkg::encode_char(ch);
      ssd_pkg::KIND_RAW_LAT: q_cmd.op = ssd_pkg::OP_PUSH;
      ssd_pkg::KIND_RAW_UNL: q_cmd.latch = 1'b0;
      ssd_pkg::KIND_CLEAR:   q_cmd.op = ssd_pkg::OP_CLEAR;
      ssd_pkg::KIND_DOTS:    q_cmd.op = ssd_pkg::OP_DOTS;
      ssd_pkg::KIND_REFRESH: q_cmd.op = ssd_pkg::OP_REFRESH;
      default:               q_push = 1'b0;  // unused kinds are dropped
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ssd_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module ssd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ssd_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output ssd_pkg::q_head_t    head
);

  ssd_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
  assign count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ssd_back.sv
// Back end: display mirror, bit serializer and output register.
`default_nettype none
module ssd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssd_pkg::q_head_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ssd_pkg::out_item_t     out_data
);

  localparam int W = ssd_pkg::MIRROR_W;
  localparam int CW = ssd_pkg::CNT_W;

  logic [W-1:0]       mirror_r, mirror_nxt;
  logic [W-1:0]       sh_r, sh_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               latch_r, latch_nxt;
  logic               out_valid_r, out_valid_nxt;
  ssd_pkg::out_item_t out_r, out_nxt;
  logic [W-1:0]       dots_word;
  logic [CW-1:0]      clear_bits;
  logic               busy, load_out, end_bit;

  assign busy       = (cnt_r != '0);
  assign pop        = head.valid && !busy;
  assign load_out   = busy && (!out_valid_r || !out_stall);
  assign end_bit    = (cnt_r == CW'(1));
  assign clear_bits = CW'({head.cmd.ndig, 3'b000});
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    dots_word = mirror_r;
    for (int i = 0; i < 8; i++) begin
      dots_word[8 * i + ssd_pkg::DOTPOSITION] = head.cmd.data[i];
    end
  end

  always_comb begin
    mirror_nxt    = mirror_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    latch_nxt     = latch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (pop) begin
      unique case (head.cmd.op)
        ssd_pkg::OP_PUSH: begin
          mirror_nxt = {mirror_r[W-9:0], head.cmd.data};
          sh_nxt     = {head.cmd.data, {(W-8){1'b0}}};
          cnt_nxt    = CW'(8);
          latch_nxt  = head.cmd.latch;
        end
        ssd_pkg::OP_CLEAR: begin
          mirror_nxt = mirror_r << clear_bits;
          sh_nxt     = '0;
          cnt_nxt    = clear_bits;
          latch_nxt  = 1'b1;
        end
        ssd_pkg::OP_DOTS: begin
          mirror_nxt = dots_word;
          sh_nxt     = dots_word;
          cnt_nxt    = CW'(W);
          latch_nxt  = 1'b1;
        end
        ssd_pkg::OP_REFRESH: begin
          sh_nxt    = mirror_r;
          cnt_nxt   = CW'(W);
          latch_nxt = 1'b1;
        end
      endcase
    end
    if (load_out) begin
      out_nxt.data_bit    = sh_r[W-1];
      out_nxt.last        = end_bit;
      out_nxt.latch_after = end_bit && latch_r;
      out_valid_nxt       = 1'b1;
      sh_nxt              = {sh_r[W-2:0], 1'b0};
      cnt_nxt             = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mirror_r    <= mirror_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    latch_r <= latch_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/seven_segment_serial_line_driver.sv
// Top level of the seven-segment serial line driver.
// An accepted transaction, when the back end is idle, is written to the queue
//   entry, popped into the serializer, then loaded into the output register.
// Throughput: one serial bit per clock from the back-end serializer while not
//   stalled; a byte command is 8 bits, a clear 8*digits, dots-only and refresh 64.
// The two-entry queue lets the front take transactions while bits go out.
// Reset (rst_n low, synchronous): mirror zero, line_length 8, queue empty.
`default_nettype none
module seven_segment_serial_line_driver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input transaction channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ssd_pkg::in_item_t  in_data,
  // serial bit channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ssd_pkg::out_item_t      out_data,
  // line_length register write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_data
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  ssd_pkg::cmd_t    q_cmd;
  ssd_pkg::q_head_t q_head;

  // Front: classifies the transaction, encodes print characters through the
  // glyph table, saturates the clear length, drops unused kinds.
  ssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // Short command queue; the front stalls only when it is full.
  ssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Back: updates the 64-bit mirror in command order and shifts bits out
  // MSB first; the last bit of a command carries last and its latch flag.
  ssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
